### rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/xcpd_pkg.sv
`timescale 1ns / 1ps

package xcpd_pkg;

  // Default depth of the result queue.
  localparam int unsigned OUTQ_DEPTH_DEF = 4;

  // Packet type codes, bits 7..6 of a packet.
  localparam logic [1:0] TYPE_HEAD = 2'b11;
  localparam logic [1:0] TYPE_BODY = 2'b10;
  localparam logic [1:0] TYPE_LAST = 2'b00;

  // Result item kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CHECK = 2'd1,
    ST_TYPE  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] nibble;
    status_t    status;
    logic       last;
  } res_t;

  // Results of one packet: up to two items, r0 first.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } step_out_t;

endpackage

### rtl/xcpd_step.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xcpd_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            pkt,
  output xcpd_pkg::step_out_t   so
);
  import xcpd_pkg::*;

  logic       in_message_r, in_message_nxt;
  logic [5:0] packets_left_r, packets_left_nxt;
  logic [2:0] prev_pay_r, prev_pay_nxt;
  logic [2:0] bit_store_r, bit_store_nxt;
  logic [1:0] bits_held_r, bits_held_nxt;

  logic [1:0] ptype;
  logic [2:0] pay;
  logic [2:0] chk;
  logic       is_last;
  logic [1:0] want;
  logic [2:0] total;
  logic [5:0] comb6;
  logic [1:0] rem;
  logic [2:0] keep_mask;

  always_comb begin
    ptype     = pkt[7:6];
    pay       = pkt[5:3];
    chk       = pkt[2:0];
    is_last   = (packets_left_r == 6'd1);
    want      = is_last ? TYPE_LAST : TYPE_BODY;
    total     = {1'b0, bits_held_r} + 3'd3;
    comb6     = {bit_store_r, pay};
    rem       = 2'(total - 3'd4);
    keep_mask = (3'b001 << rem) - 3'b001;

    in_message_nxt   = in_message_r;
    packets_left_nxt = packets_left_r;
    prev_pay_nxt     = prev_pay_r;
    bit_store_nxt    = bit_store_r;
    bits_held_nxt    = bits_held_r;
    so               = '0;

    if (fire) begin
      if (!in_message_r) begin
        if (ptype != TYPE_HEAD) begin
          so.cnt       = 2'd1;
          so.r0.kind   = KIND_STATUS;
          so.r0.status = ST_TYPE;
        end else if (pkt[5:0] == 6'd0) begin
          so.cnt       = 2'd1;
          so.r0.kind   = KIND_STATUS;
          so.r0.status = ST_EMPTY;
        end else begin
          in_message_nxt   = 1'b1;
          packets_left_nxt = pkt[5:0];
          prev_pay_nxt     = pay;
          bit_store_nxt    = 3'd0;
          bits_held_nxt    = 2'd0;
        end
      end else if (ptype != want) begin
        so.cnt           = 2'd1;
        so.r0.kind       = KIND_STATUS;
        so.r0.status     = ST_TYPE;
        in_message_nxt   = 1'b0;
        packets_left_nxt = 6'd0;
        bit_store_nxt    = 3'd0;
        bits_held_nxt    = 2'd0;
      end else if (chk != (prev_pay_r ^ pay)) begin
        so.cnt           = 2'd1;
        so.r0.kind       = KIND_STATUS;
        so.r0.status     = ST_CHECK;
        in_message_nxt   = 1'b0;
        packets_left_nxt = 6'd0;
        bit_store_nxt    = 3'd0;
        bits_held_nxt    = 2'd0;
      end else begin
        if (total >= 3'd4) begin
          // A nibble completes: emit the oldest four bits, keep the rest.
          so.cnt        = 2'd1;
          so.r0.kind    = KIND_DATA;
          so.r0.nibble  = 4'(comb6 >> rem);
          so.r0.status  = ST_OK;
          bit_store_nxt = comb6[2:0] & keep_mask;
          bits_held_nxt = rem;
        end else begin
          bit_store_nxt = comb6[2:0];
          bits_held_nxt = 2'(total);
        end
        prev_pay_nxt     = pay;
        packets_left_nxt = packets_left_r - 6'd1;
        if (is_last) begin
          if (so.cnt == 2'd1) begin
            so.cnt       = 2'd2;
            so.r1.kind   = KIND_STATUS;
            so.r1.status = ST_OK;
          end else begin
            so.cnt       = 2'd1;
            so.r0.kind   = KIND_STATUS;
            so.r0.status = ST_OK;
          end
          // Leftover bits are dropped when the message closes.
          in_message_nxt   = 1'b0;
          packets_left_nxt = 6'd0;
          bit_store_nxt    = 3'd0;
          bits_held_nxt    = 2'd0;
        end
      end
      if (so.cnt == 2'd1) begin
        so.r0.last = 1'b1;
      end else if (so.cnt == 2'd2) begin
        so.r1.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_message_r   <= 1'b0;
      packets_left_r <= 6'd0;
      prev_pay_r     <= 3'd0;
      bit_store_r    <= 3'd0;
      bits_held_r    <= 2'd0;
    end else begin
      in_message_r   <= in_message_nxt;
      packets_left_r <= packets_left_nxt;
      prev_pay_r     <= prev_pay_nxt;
      bit_store_r    <= bit_store_nxt;
      bits_held_r    <= bits_held_nxt;
    end
  end

  `ASSERT_ON_CLK(a_left_nonzero, in_message_r |-> (packets_left_r != 6'd0), "open message has no packets left")
  `ASSERT_ON_CLK(a_pair_shape, (so.cnt == 2'd2) |-> (so.r0.kind == KIND_DATA && so.r1.kind == KIND_STATUS && so.r1.status == ST_OK), "two results must be a nibble then an ok status")
  `ASSERT_ON_CLK(a_idle_clear, !in_message_r |-> (bits_held_r == 2'd0), "bits held while idle")

endmodule

### rtl/xcpd_outq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xcpd_outq #(
  parameter int unsigned DEPTH = xcpd_pkg::OUTQ_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  xcpd_pkg::res_t    wr0,
  input  xcpd_pkg::res_t    wr1,
  input  logic              pop,
  output logic              room2,
  output logic              head_vld,
  output xcpd_pkg::res_t    head
);
  import xcpd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wptr_p1;
  logic          do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wptr_p1  = ptr_inc(wptr_r);
    do_pop   = pop && (count_r != '0);
    head_vld = (count_r != '0);
    head     = mem[rptr_r];
    room2    = (count_r <= CW'(DEPTH - 2));
    rptr_nxt = do_pop ? ptr_inc(rptr_r) : rptr_r;
    case (push_cnt)
      2'd1:    wptr_nxt = wptr_p1;
      2'd2:    wptr_nxt = ptr_inc(wptr_p1);
      default: wptr_nxt = wptr_r;
    endcase
    count_nxt = count_r + CW'(push_cnt) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wptr_r] <= wr0;
    end
    if (push_cnt == 2'd2) begin
      mem[wptr_p1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  `ASSERT_ON_CLK(a_count_bound, count_r <= CW'(DEPTH), "result queue overfilled")
  `ASSERT_ON_CLK(a_push_room, (push_cnt != 2'd0) |-> room2, "results pushed without two free entries")
  `ASSERT_ON_CLK(a_head_hold, (head_vld && !pop) |=> (head_vld && $stable(head)), "head moved while held")

endmodule

### rtl/xor_checked_packet_deframer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_packet_byte
// out_      output     out_valid/out_stall out_item_kind, out_hex_nibble,
//                                          out_message_status, out_last_of_run
//
// One packet is accepted per cycle while the result queue keeps up; up to two
// results leave per packet, one per cycle while out_stall is low. A packet
// waits in the input register until the queue has two free entries; its
// results are then written to the queue, whose head is offered at the output.
// in_stall rises only while the input register is full and the result queue
// has fewer than two free entries; out_stall holds the queue head in place.
// rst_n is synchronous and active low; it empties both registers and returns
// the deframer to idle, awaiting a header.

module xor_checked_packet_deframer #(
  parameter int unsigned OUTQ_DEPTH = xcpd_pkg::OUTQ_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_packet_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_item_kind,
  output logic [3:0] out_hex_nibble,
  output logic [1:0] out_message_status,
  output logic       out_last_of_run
);
  import xcpd_pkg::*;

  // Input register: holds one item until the queue can take all its results.
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r, in_byte_nxt;

  logic       room2;
  logic       consume;
  logic       accept;
  logic       head_vld;
  res_t       head;
  step_out_t  so;

  always_comb begin
    // Processing an item needs two free queue entries, the most any item makes.
    consume     = in_vld_r && room2;
    in_stall    = in_vld_r && !room2;
    accept      = in_valid && !in_stall;
    in_vld_nxt  = accept ? 1'b1 : (consume ? 1'b0 : in_vld_r);
    in_byte_nxt = accept ? in_packet_byte : in_byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
  end

  // Header check, XOR check and nibble packing, with the message state.
  xcpd_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (consume),
    .pkt   (in_byte_r),
    .so    (so)
  );

  // Result queue; its head is the output register.
  xcpd_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (so.cnt),
    .wr0      (so.r0),
    .wr1      (so.r1),
    .pop      (!out_stall),
    .room2    (room2),
    .head_vld (head_vld),
    .head     (head)
  );

  assign out_valid          = head_vld;
  assign out_item_kind      = head.kind;
  assign out_hex_nibble     = head.nibble;
  assign out_message_status = head.status;
  assign out_last_of_run    = head.last;

  `ASSERT_ALWAYS(a_stall_full, in_stall |-> in_vld_r, "input stalled with an empty input register")
  `ASSERT_ON_CLK(a_accept_load, accept |=> in_vld_r, "accepted item not held")
  `ASSERT_ON_CLK(a_out_hold, (out_valid && out_stall) |=> out_valid, "stalled result withdrawn")

endmodule

### tb/xcpd_result_checker.sv
`timescale 1ns / 1ps

module xcpd_result_checker
  import xcpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_packet_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_item_kind,
  input  logic [3:0] out_hex_nibble,
  input  logic [1:0] out_message_status,
  input  logic       out_last_of_run,
  output int         mismatch_count,
  output int         items_awaited
);

  // Results predicted but not yet seen, oldest first.
  res_t awaited_items[$];
  res_t head;
  int   fails = 0;

  // Predicted deframer state.
  logic       msg_open     = 1'b0;
  logic [5:0] packets_left = '0;
  logic [2:0] prev_payload = '0;
  logic [2:0] held_bits    = '0;
  logic [1:0] held_count   = '0;

  initial begin
    mismatch_count = 0;
    items_awaited  = 0;
  end

  function automatic res_t status_item(input status_t code);
    res_t r;
    r.kind   = KIND_STATUS;
    r.nibble = 4'd0;
    r.status = code;
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic close_message();
    msg_open     = 1'b0;
    packets_left = '0;
    held_bits    = '0;
    held_count   = '0;
  endtask

  // Works out the results of one packet and queues them.
  task automatic deframe_packet(input logic [7:0] pkt);
    res_t       produced[$];
    res_t       nib_item;
    res_t       tail;
    logic       closing;
    logic [1:0] wanted_type;
    logic [2:0] payload;
    logic [2:0] total;
    logic [5:0] joined;
    logic [1:0] spare;
    payload = pkt[5:3];
    if (!msg_open) begin
      if (pkt[7:6] != TYPE_HEAD) begin
        produced.push_back(status_item(ST_TYPE));
      end else if (pkt[5:0] == 6'd0) begin
        produced.push_back(status_item(ST_EMPTY));
      end else begin
        msg_open     = 1'b1;
        packets_left = pkt[5:0];
        prev_payload = payload;
        held_bits    = '0;
        held_count   = '0;
      end
    end else begin
      closing     = (packets_left == 6'd1);
      wanted_type = closing ? TYPE_LAST : TYPE_BODY;
      if (pkt[7:6] != wanted_type) begin
        produced.push_back(status_item(ST_TYPE));
        close_message();
      end else if (pkt[2:0] != (prev_payload ^ payload)) begin
        produced.push_back(status_item(ST_CHECK));
        close_message();
      end else begin
        total  = {1'b0, held_count} + 3'd3;
        joined = {held_bits, payload};
        if (total >= 3'd4) begin
          spare           = 2'(total - 3'd4);
          nib_item.kind   = KIND_DATA;
          nib_item.nibble = 4'(joined >> spare);
          nib_item.status = ST_OK;
          nib_item.last   = 1'b0;
          produced.push_back(nib_item);
          held_bits  = 3'(joined & ((6'd1 << spare) - 6'd1));
          held_count = spare;
        end else begin
          held_bits  = joined[2:0];
          held_count = total[1:0];
        end
        prev_payload = payload;
        packets_left = packets_left - 6'd1;
        if (closing) begin
          produced.push_back(status_item(ST_OK));
          close_message();
        end
      end
    end
    if (produced.size() > 0) begin
      tail      = produced.pop_back();
      tail.last = 1'b1;
      produced.push_back(tail);
    end
    foreach (produced[i]) awaited_items.push_back(produced[i]);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      deframe_packet(in_packet_byte);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_items.size() == 0) begin
        $error("unexpected result item: kind %0d nibble %0h status %0d last %0d",
               out_item_kind, out_hex_nibble, out_message_status, out_last_of_run);
        fails++;
      end else begin
        head = awaited_items.pop_front();
        if (out_item_kind !== head.kind) begin
          $error("item_kind: expected %0d, got %0d", head.kind, out_item_kind);
          fails++;
        end
        if (out_hex_nibble !== head.nibble) begin
          $error("hex_nibble: expected %0h, got %0h", head.nibble, out_hex_nibble);
          fails++;
        end
        if (out_message_status !== head.status) begin
          $error("message_status: expected %0d, got %0d", head.status, out_message_status);
          fails++;
        end
        if (out_last_of_run !== head.last) begin
          $error("last_of_run: expected %0d, got %0d", head.last, out_last_of_run);
          fails++;
        end
      end
    end
    mismatch_count <= fails;
    items_awaited  <= awaited_items.size();
  end

endmodule

### tb/xor_checked_packet_deframer_tb.sv
`timescale 1ns / 1ps

module xor_checked_packet_deframer_tb;
  import xcpd_pkg::*;

  // Ways in which a generated message may be spoilt on purpose.
  typedef enum int {
    FLAW_NONE,
    FLAW_TYPE,
    FLAW_CHECK
  } flaw_t;

  // Every input of the block has a known value from time zero.
  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] in_packet_byte = 8'h00;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic       out_item_kind;
  logic [3:0] out_hex_nibble;
  logic [1:0] out_message_status;
  logic       out_last_of_run;

  int   mismatch_count;
  int   items_awaited;
  int   packets_sent = 0;
  int   stall_left   = 0;
  int   pick;
  int   size;
  // Once set, neither side idles any more, so the tail of the run goes at full rate.
  logic calm = 1'b0;

  always #6 clk = ~clk;

  xor_checked_packet_deframer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_packet_byte     (in_packet_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_kind      (out_item_kind),
    .out_hex_nibble     (out_hex_nibble),
    .out_message_status (out_message_status),
    .out_last_of_run    (out_last_of_run)
  );

  // The checker watches both channels, predicts every result and compares;
  // this module only makes stimulus and gives the verdict.
  xcpd_result_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_packet_byte     (in_packet_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_kind      (out_item_kind),
    .out_hex_nibble     (out_hex_nibble),
    .out_message_status (out_message_status),
    .out_last_of_run    (out_last_of_run),
    .mismatch_count     (mismatch_count),
    .items_awaited      (items_awaited)
  );

  // The receiving side stalls in bursts. A burst starts with a modest chance on
  // any free cycle, so long stall-free stretches occur as well.
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one packet and returns at the edge where it is taken. Now and then a
  // gap of idle cycles is put in front of it. The packet is held steady while
  // the block stalls, and valid never looks at the stall.
  task automatic send_packet(input logic [7:0] pkt);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_packet_byte <= pkt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    packets_sent++;
  endtask

  // Sends a header with the given count and then the counted packets with
  // random payloads and correct check bits. With a flaw, the packet at flaw_at
  // gets a wrong type or wrong check bits, and the message stops there since
  // the block abandons it.
  task automatic send_message(input int count, input flaw_t flaw, input int flaw_at);
    logic [2:0] prev;
    logic [2:0] payload;
    logic [1:0] ptype;
    logic [2:0] check;
    // The header's own bits 5..3 seed the check of the first packet.
    prev = 3'(count >> 3);
    send_packet({TYPE_HEAD, 6'(count)});
    for (int i = 0; i < count; i++) begin
      payload = 3'($urandom_range(0, 7));
      ptype   = (i == count - 1) ? TYPE_LAST : TYPE_BODY;
      check   = prev ^ payload;
      if (i == flaw_at && flaw == FLAW_TYPE) begin
        // Adding 1 to 3 modulo 4 always gives one of the other three types.
        ptype = 2'(ptype + $urandom_range(1, 3));
      end
      if (i == flaw_at && flaw == FLAW_CHECK) begin
        check = check ^ 3'($urandom_range(1, 7));
      end
      send_packet({ptype, payload, check});
      if (i == flaw_at && flaw != FLAW_NONE) break;
      prev = payload;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Packets of a non-header type while idle, among them the
    // all-zero packet and 8'h7F, each give a type error on their own.
    send_packet(8'h00);
    send_packet(8'h80);
    send_packet(8'h7F);
    // A header with a count of zero reports an empty message.
    send_packet(8'hC0);
    // A one-packet message: three payload bits never fill a nibble, so they are
    // dropped and only the ok status comes out.
    send_packet(8'hC1);
    send_packet(8'h3F);
    // Four packets make three nibbles; the last packet yields a nibble and the
    // status together. Two packets leave two bits over.
    send_message(4, FLAW_NONE, 0);
    send_message(2, FLAW_NONE, 0);
    // A header type inside a message abandons it.
    send_packet(8'hC2);
    send_packet(8'hC7);
    // A body packet whose check bits disagree with the payloads.
    send_packet(8'hC2);
    send_packet(8'hA8);
    // A body type where the counted last packet was due.
    send_packet(8'hC1);
    send_packet(8'h80);
    // The largest count, one good body packet, then a last-type packet far too early.
    send_packet(8'hFF);
    send_packet(8'hB8);
    send_packet(8'h00);

    // Random part: mostly well-formed messages with random payloads, some
    // spoilt ones and a little noise. Counts are mostly small, with the odd
    // long message up to the full count of 63.
    while (packets_sent < 950) begin
      if (packets_sent >= 850 && !calm) calm <= 1'b1;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        size = 63;
      end else if (pick < 3) begin
        size = $urandom_range(9, 62);
      end else begin
        size = $urandom_range(1, 8);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_packet(8'($urandom));
      end else if (pick == 1) begin
        send_message(size, ($urandom_range(0, 1) == 0) ? FLAW_TYPE : FLAW_CHECK,
                     $urandom_range(0, size - 1));
      end else begin
        send_message(size, FLAW_NONE, 0);
      end
    end
    in_valid <= 1'b0;

    // Let the checker see the last packet, drain every awaited result, and
    // then keep watching for anything the block might still emit.
    @(posedge clk);
    while (items_awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && items_awaited == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, which is well under 0.5 ms.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
